// ===== rtl/njcs_pkg.sv =====
package njcs_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int MAX_JOINTS_DEF = 8;
    localparam int LANE_SLOTS     = 8;

    localparam int ANGLE_W = 16;
    localparam int DOF_W   = 4;
    localparam int INDEX_W = 10;
    localparam int DIST_W  = 34;
    localparam int MAG_W   = 17;
    localparam int SQ_W    = 31;
    localparam int PAIR_W  = 32;
    localparam int QUAD_W  = 33;

    localparam logic [DOF_W-1:0] DOF_RESET = 4'd8;

    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic [SQ_W-1:0]    sq_t;

    typedef enum logic [0:0] {
        MODE_INSERT = 1'b0,
        MODE_QUERY  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // scan beat tag, travels alongside the lane data
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

endpackage

// ===== rtl/nearest_joint_config_search.sv =====
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------------
// cfg      | in        | cfg_valid / cfg_ready  | cfg_data (dof_count, 4 bits)
// in       | in        | in_valid / in_ready    | mode, angle_0 .. angle_7
// out      | out       | out_valid / out_ready  | node_index, distance_sq, status
//
// a query beat runs a scan that reads one stored node per cycle from every joint lane
// (memory read, square, three adder levels, compare); an insert beat needs no scan
// one beat is worked on at a time; the input side may take a new beat while a result
// still waits in the output register
// rst_n is asynchronous, active low; it clears the node count, sets dof_count to 8,
// and needs no clearing pass since the node memories are only read below the count
// a stalled output parks a finished result in a pending register until the slot frees
module nearest_joint_config_search #(
    parameter int MAX_NODES  = njcs_pkg::MAX_NODES_DEF,
    parameter int MAX_JOINTS = njcs_pkg::MAX_JOINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [njcs_pkg::DOF_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  njcs_pkg::angle_t                  angle_0,
    input  njcs_pkg::angle_t                  angle_1,
    input  njcs_pkg::angle_t                  angle_2,
    input  njcs_pkg::angle_t                  angle_3,
    input  njcs_pkg::angle_t                  angle_4,
    input  njcs_pkg::angle_t                  angle_5,
    input  njcs_pkg::angle_t                  angle_6,
    input  njcs_pkg::angle_t                  angle_7,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [njcs_pkg::INDEX_W-1:0]      node_index,
    output logic [njcs_pkg::DIST_W-1:0]       distance_sq,
    output logic [1:0]                        status
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    njcs_pkg::state_t               state_reg, state_next;
    logic [njcs_pkg::DOF_W-1:0]     dof_count_reg;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [IDX_W-1:0]               scan_reg, scan_next;

    // finished result waiting for the output slot
    logic [njcs_pkg::INDEX_W-1:0]   pend_index_reg, pend_index_next;
    logic [njcs_pkg::DIST_W-1:0]    pend_dist_reg, pend_dist_next;
    njcs_pkg::status_t              pend_status_reg, pend_status_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic [njcs_pkg::INDEX_W-1:0]   out_index_reg, out_index_next;
    logic [njcs_pkg::DIST_W-1:0]    out_dist_reg, out_dist_next;
    njcs_pkg::status_t              out_status_reg, out_status_next;

    njcs_pkg::angle_t               angle_in [njcs_pkg::LANE_SLOTS];
    njcs_pkg::angle_t               query_reg [MAX_JOINTS];
    njcs_pkg::sq_t                  lane_sq [MAX_JOINTS];
    logic [MAX_JOINTS-1:0]          lane_en;

    njcs_pkg::tag_t                 issue_tag, tag_d1_reg, tag_d2_reg;
    logic [IDX_W-1:0]               idx_d1_reg, idx_d2_reg;
    logic                           wr_en;
    logic                           in_fire;
    logic                           out_free;
    logic                           last_issue;
    logic                           merge_done;
    logic [IDX_W-1:0]               merge_idx;
    logic [njcs_pkg::DIST_W-1:0]    merge_dist;

    assign angle_in[0] = angle_0;
    assign angle_in[1] = angle_1;
    assign angle_in[2] = angle_2;
    assign angle_in[3] = angle_3;
    assign angle_in[4] = angle_4;
    assign angle_in[5] = angle_5;
    assign angle_in[6] = angle_6;
    assign angle_in[7] = angle_7;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == njcs_pkg::S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // last node of the scan is at count - 1
    assign last_issue = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_next        = scan_reg;
        pend_index_next  = pend_index_reg;
        pend_dist_next   = pend_dist_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_index_next   = out_index_reg;
        out_dist_next    = out_dist_reg;
        out_status_next  = out_status_reg;
        issue_tag        = '0;
        wr_en            = 1'b0;

        case (state_reg)
            njcs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (njcs_pkg::mode_t'(mode) == njcs_pkg::MODE_QUERY
                        && count_reg != '0)
                    begin
                        scan_next  = '0;
                        state_next = njcs_pkg::S_SCAN;
                    end
                    else
                    begin
                        // insert or empty query: result is known right away
                        pend_index_next  = '0;
                        pend_dist_next   = '0;
                        if (njcs_pkg::mode_t'(mode) == njcs_pkg::MODE_QUERY)
                        begin
                            pend_status_next = njcs_pkg::STATUS_EMPTY;
                        end
                        else if (count_reg == CNT_W'(MAX_NODES))
                        begin
                            pend_status_next = njcs_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            pend_index_next  = njcs_pkg::INDEX_W'(count_reg);
                            pend_status_next = njcs_pkg::STATUS_OK;
                            count_next       = count_reg + CNT_W'(1);
                        end
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_index_next  = pend_index_next;
                            out_dist_next   = pend_dist_next;
                            out_status_next = pend_status_next;
                        end
                        else
                        begin
                            state_next = njcs_pkg::S_HOLD;
                        end
                    end
                end
            end
            njcs_pkg::S_SCAN:
            begin
                issue_tag.valid = 1'b1;
                issue_tag.first = (scan_reg == '0);
                issue_tag.last  = last_issue;
                if (last_issue)
                begin
                    state_next = njcs_pkg::S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            njcs_pkg::S_DRAIN:
            begin
                if (merge_done)
                begin
                    pend_index_next  = njcs_pkg::INDEX_W'(merge_idx);
                    pend_dist_next   = merge_dist;
                    pend_status_next = njcs_pkg::STATUS_OK;
                    state_next       = njcs_pkg::S_HOLD;
                end
            end
            njcs_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = pend_index_reg;
                    out_dist_next   = pend_dist_reg;
                    out_status_next = pend_status_reg;
                    state_next      = njcs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = njcs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= njcs_pkg::S_IDLE;
            dof_count_reg <= njcs_pkg::DOF_RESET;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            tag_d1_reg    <= '0;
            tag_d2_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            tag_d1_reg    <= issue_tag;
            tag_d2_reg    <= tag_d1_reg;
            if (cfg_valid && cfg_ready)
            begin
                dof_count_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_index_reg  <= pend_index_next;
        pend_dist_reg   <= pend_dist_next;
        pend_status_reg <= pend_status_next;
        out_index_reg   <= out_index_next;
        out_dist_reg    <= out_dist_next;
        out_status_reg  <= out_status_next;
        idx_d1_reg      <= scan_reg;
        idx_d2_reg      <= idx_d1_reg;
        if (in_fire)
        begin
            for (int j = 0; j < MAX_JOINTS; j++)
            begin
                query_reg[j] <= angle_in[j];
            end
        end
    end

    // one lane per joint, each with its own column of the node table
    for (genvar j = 0; j < MAX_JOINTS; j++)
    begin : g_lane
        // dof_count of zero still uses joint zero; above the lane count uses all
        assign lane_en[j] = (j == 0) || (dof_count_reg > njcs_pkg::DOF_W'(j));

        njcs_lane #(
            .MAX_NODES (MAX_NODES),
            .IDX_W     (IDX_W)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (wr_en),
            .wr_addr     (count_reg[IDX_W-1:0]),
            .wr_data     (angle_in[j]),
            .rd_addr     (scan_reg),
            .query_angle (query_reg[j]),
            .lane_en     (lane_en[j]),
            .sq          (lane_sq[j])
        );
    end

    njcs_merge #(
        .MAX_JOINTS (MAX_JOINTS),
        .IDX_W      (IDX_W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (tag_d2_reg),
        .idx_in    (idx_d2_reg),
        .sq_in     (lane_sq),
        .done      (merge_done),
        .best_idx  (merge_idx),
        .best_dist (merge_dist)
    );

    assign out_valid   = out_valid_reg;
    assign node_index  = out_index_reg;
    assign distance_sq = out_dist_reg;
    assign status      = out_status_reg;

endmodule

// ===== rtl/njcs_lane.sv =====
module njcs_lane #(
    parameter int MAX_NODES = njcs_pkg::MAX_NODES_DEF,
    parameter int IDX_W     = $clog2(MAX_NODES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  njcs_pkg::angle_t wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    input  njcs_pkg::angle_t query_angle,
    input  logic             lane_en,
    output njcs_pkg::sq_t    sq
);

    njcs_pkg::angle_t mem [MAX_NODES];
    njcs_pkg::angle_t rd_data_reg;
    njcs_pkg::sq_t    sq_reg;
    njcs_pkg::angle_t diff;
    logic [njcs_pkg::MAG_W-1:0] mag;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // wrapped difference, magnitude folded to at most a half turn
    always_comb
    begin
        diff = query_angle - rd_data_reg;
        if (diff[njcs_pkg::ANGLE_W-1])
        begin
            mag = 17'h10000 - {1'b0, diff};
        end
        else
        begin
            mag = {1'b0, diff};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg <= '0;
        end
        else if (lane_en)
        begin
            sq_reg <= njcs_pkg::SQ_W'(mag * mag);
        end
        else
        begin
            sq_reg <= '0;
        end
    end

    assign sq = sq_reg;

endmodule

// ===== rtl/njcs_merge.sv =====
module njcs_merge #(
    parameter int MAX_JOINTS = njcs_pkg::MAX_JOINTS_DEF,
    parameter int IDX_W      = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  njcs_pkg::tag_t                tag_in,
    input  logic [IDX_W-1:0]              idx_in,
    input  njcs_pkg::sq_t                 sq_in [MAX_JOINTS],
    output logic                          done,
    output logic [IDX_W-1:0]              best_idx,
    output logic [njcs_pkg::DIST_W-1:0]   best_dist
);

    njcs_pkg::sq_t                  pad [njcs_pkg::LANE_SLOTS];
    logic [njcs_pkg::PAIR_W-1:0]    pair_reg [4];
    logic [njcs_pkg::QUAD_W-1:0]    quad_reg [2];
    logic [njcs_pkg::DIST_W-1:0]    total_reg;
    njcs_pkg::tag_t                 tag_a_reg, tag_b_reg, tag_c_reg;
    logic [IDX_W-1:0]               idx_a_reg, idx_b_reg, idx_c_reg;
    logic [IDX_W-1:0]               best_idx_reg;
    logic [njcs_pkg::DIST_W-1:0]    best_dist_reg;
    logic                           done_reg;

    always_comb
    begin
        for (int k = 0; k < njcs_pkg::LANE_SLOTS; k++)
        begin
            pad[k] = '0;
        end
        for (int k = 0; k < MAX_JOINTS; k++)
        begin
            pad[k] = sq_in[k];
        end
    end

    // three-level registered adder tree
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            pair_reg[k] <= njcs_pkg::PAIR_W'(pad[2*k]) + njcs_pkg::PAIR_W'(pad[2*k+1]);
        end
        for (int k = 0; k < 2; k++)
        begin
            quad_reg[k] <= njcs_pkg::QUAD_W'(pair_reg[2*k])
                         + njcs_pkg::QUAD_W'(pair_reg[2*k+1]);
        end
        total_reg <= njcs_pkg::DIST_W'(quad_reg[0]) + njcs_pkg::DIST_W'(quad_reg[1]);
        idx_a_reg <= idx_in;
        idx_b_reg <= idx_a_reg;
        idx_c_reg <= idx_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            done_reg  <= tag_c_reg.valid && tag_c_reg.last;
        end
    end

    // strict less-than keeps the lowest index on ties
    always_ff @(posedge clk)
    begin
        if (tag_c_reg.valid && (tag_c_reg.first || (total_reg < best_dist_reg)))
        begin
            best_dist_reg <= total_reg;
            best_idx_reg  <= idx_c_reg;
        end
    end

    assign done      = done_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule

// ===== tb/sv/nearest_result_checker.sv =====
`timescale 1ns / 100ps

// watches the three channels, keeps its own copy of the node table and
// the joint count, and checks every result beat against the oldest answer due
module nearest_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [njcs_pkg::DOF_W-1:0]       cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             mode,
    input  njcs_pkg::angle_t                 angle_0,
    input  njcs_pkg::angle_t                 angle_1,
    input  njcs_pkg::angle_t                 angle_2,
    input  njcs_pkg::angle_t                 angle_3,
    input  njcs_pkg::angle_t                 angle_4,
    input  njcs_pkg::angle_t                 angle_5,
    input  njcs_pkg::angle_t                 angle_6,
    input  njcs_pkg::angle_t                 angle_7,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [njcs_pkg::INDEX_W-1:0]     node_index,
    input  logic [njcs_pkg::DIST_W-1:0]      distance_sq,
    input  logic [1:0]                       status,
    output int                               errors,
    output int                               pending,
    output int                               results,
    output int                               queries,
    output int                               empties,
    output int                               fulls
);

    typedef logic [njcs_pkg::MAX_JOINTS_DEF-1:0][njcs_pkg::ANGLE_W-1:0] joint_vec_t;

    typedef struct packed {
        logic [njcs_pkg::INDEX_W-1:0] idx;
        logic [njcs_pkg::DIST_W-1:0]  dist_sq;
        njcs_pkg::status_t            st;
    } answer_t;

    joint_vec_t                 node_table [njcs_pkg::MAX_NODES_DEF];
    int                         stored;
    logic [njcs_pkg::DOF_W-1:0] dof;
    answer_t                    answers_due [$];

    // squared magnitude of the shorter way round between two binary angles
    function automatic logic [njcs_pkg::DIST_W-1:0] wrapped_sq(njcs_pkg::angle_t a,
                                                               njcs_pkg::angle_t b);
        njcs_pkg::angle_t           diff;
        logic [njcs_pkg::MAG_W-1:0] mag;
        diff = b - a;
        mag = diff[njcs_pkg::ANGLE_W-1]
            ? ((njcs_pkg::MAG_W'(1) << njcs_pkg::ANGLE_W) - njcs_pkg::MAG_W'(diff))
            : njcs_pkg::MAG_W'(diff);
        return njcs_pkg::DIST_W'(mag) * njcs_pkg::DIST_W'(mag);
    endfunction

    function automatic answer_t nearest_answer(joint_vec_t q);
        answer_t                     ans;
        logic [njcs_pkg::DIST_W-1:0] sum;
        int                          lanes;
        int                          i;
        int                          j;
        ans = '{idx: '0, dist_sq: '0, st: njcs_pkg::STATUS_EMPTY};
        if (stored == 0)
            return ans;
        // zero acts as one joint, anything past the lane count as all lanes
        lanes = (dof == 0) ? 1
              : ((dof > njcs_pkg::MAX_JOINTS_DEF) ? njcs_pkg::MAX_JOINTS_DEF : int'(dof));
        ans.st = njcs_pkg::STATUS_OK;
        for (i = 0; i < stored; i++)
        begin
            sum = '0;
            for (j = 0; j < lanes; j++)
                sum += wrapped_sq(node_table[i][j], q[j]);
            // strict less-than keeps the lowest index on ties
            if (i == 0 || sum < ans.dist_sq)
            begin
                ans.dist_sq = sum;
                ans.idx     = njcs_pkg::INDEX_W'(i);
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        joint_vec_t q;
        answer_t    due;
        int         bad;
        if (!rst_n)
        begin
            stored = 0;
            dof    = njcs_pkg::DOF_RESET;
            answers_due.delete();
            errors  <= 0;
            pending <= 0;
            results <= 0;
            queries <= 0;
            empties <= 0;
            fulls   <= 0;
        end
        else
        begin
            bad = 0;
            if (out_valid && out_ready)
            begin
                results <= results + 1;
                if (answers_due.size() == 0)
                begin
                    $error("result beat with nothing outstanding: node_index %0d status %0d",
                           node_index, status);
                    bad++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (node_index !== due.idx)
                    begin
                        $error("node_index mismatch: expected %0d, got %0d", due.idx, node_index);
                        bad++;
                    end
                    if (distance_sq !== due.dist_sq)
                    begin
                        $error("distance_sq mismatch: expected %0d, got %0d",
                               due.dist_sq, distance_sq);
                        bad++;
                    end
                    if (status !== due.st)
                    begin
                        $error("status mismatch: expected %0d, got %0d", due.st, status);
                        bad++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                dof = cfg_data;
            if (in_valid && in_ready)
            begin
                q = {angle_7, angle_6, angle_5, angle_4, angle_3, angle_2, angle_1, angle_0};
                if (mode == njcs_pkg::MODE_INSERT)
                begin
                    due = '{idx: '0, dist_sq: '0, st: njcs_pkg::STATUS_FULL};
                    if (stored < njcs_pkg::MAX_NODES_DEF)
                    begin
                        node_table[stored] = q;
                        due.idx = njcs_pkg::INDEX_W'(stored);
                        due.st  = njcs_pkg::STATUS_OK;
                        stored++;
                    end
                    else
                        fulls <= fulls + 1;
                end
                else
                begin
                    due = nearest_answer(q);
                    if (due.st == njcs_pkg::STATUS_EMPTY)
                        empties <= empties + 1;
                    else
                        queries <= queries + 1;
                end
                answers_due.insert(answers_due.size(), due);
            end
            errors  <= errors + bad;
            pending <= answers_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_nearest_joint_config_search.sv =====
`timescale 1ns / 100ps

module tb_nearest_joint_config_search;

    typedef logic [njcs_pkg::MAX_JOINTS_DEF-1:0][njcs_pkg::ANGLE_W-1:0] joint_vec_t;

    // block ports, every input known from time zero
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [njcs_pkg::DOF_W-1:0]    cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic                          mode      = 1'b0;
    njcs_pkg::angle_t              angle_0   = '0;
    njcs_pkg::angle_t              angle_1   = '0;
    njcs_pkg::angle_t              angle_2   = '0;
    njcs_pkg::angle_t              angle_3   = '0;
    njcs_pkg::angle_t              angle_4   = '0;
    njcs_pkg::angle_t              angle_5   = '0;
    njcs_pkg::angle_t              angle_6   = '0;
    njcs_pkg::angle_t              angle_7   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [njcs_pkg::INDEX_W-1:0]  node_index;
    logic [njcs_pkg::DIST_W-1:0]   distance_sq;
    logic [1:0]                    status;

    // checker outputs
    int errors;
    int pending;
    int results;
    int queries;
    int empties;
    int fulls;

    // idle percentages for sender and receiver, changed per phase
    int send_idle = 0;
    int recv_idle = 0;

    // one long receiver hold-off, requested by the stimulus process
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left  = 0;

    // configurations inserted so far that the table accepted, used to aim queries
    joint_vec_t placed [$];

    nearest_joint_config_search uut (.*);

    nearest_result_checker watcher (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off counted here so the block
    // backs up into its input while the sender keeps offering beats
    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = 600;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic joint_vec_t rand_vec();
        joint_vec_t w;
        int         j;
        for (j = 0; j < njcs_pkg::MAX_JOINTS_DEF; j++)
            w[j] = njcs_pkg::ANGLE_W'($urandom_range(65535));
        return w;
    endfunction

    // small random offset on every joint, wrapping through zero where it lands
    function automatic joint_vec_t nudge(joint_vec_t base, int span);
        joint_vec_t w;
        int         j;
        int         delta;
        w = base;
        for (j = 0; j < njcs_pkg::MAX_JOINTS_DEF; j++)
        begin
            delta = int'($urandom_range(2 * span)) - span;
            w[j] = w[j] + njcs_pkg::ANGLE_W'(delta);
        end
        return w;
    endfunction

    // offer one beat, with an optional gap first; valid stays high on return
    task automatic send(input logic m, input joint_vec_t v);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        angle_0  <= v[0];
        angle_1  <= v[1];
        angle_2  <= v[2];
        angle_3  <= v[3];
        angle_4  <= v[4];
        angle_5  <= v[5];
        angle_6  <= v[6];
        angle_7  <= v[7];
        do @(posedge clk); while (!in_ready);
        if (m == njcs_pkg::MODE_INSERT && placed.size() < njcs_pkg::MAX_NODES_DEF)
            placed.insert(placed.size(), v);
    endtask

    // sender pauses until every outstanding result is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (12) @(posedge clk);
    endtask

    // joint count only changes with the block idle
    task automatic write_dof(input logic [njcs_pkg::DOF_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-aimed beats: inserts that repeat or sit near stored nodes,
    // queries near, on, or half a turn away from stored nodes, plus plain noise
    task automatic random_item();
        logic       m;
        joint_vec_t v;
        int         pick;
        int         r;
        m    = ($urandom_range(99) < 45) ? njcs_pkg::MODE_INSERT : njcs_pkg::MODE_QUERY;
        pick = $urandom_range(placed.size() - 1);
        r    = $urandom_range(99);
        if (m == njcs_pkg::MODE_INSERT)
        begin
            if (r < 50)
                v = rand_vec();
            else if (r < 75)
                v = placed[pick];
            else
                v = nudge(placed[pick], 64);
        end
        else
        begin
            if (r < 40)
                v = nudge(placed[pick], 300);
            else if (r < 55)
                v = placed[pick];
            else if (r < 70)
            begin
                v = placed[pick];
                v[$urandom_range(njcs_pkg::MAX_JOINTS_DEF - 1)] ^= 16'h8000;
            end
            else
                v = rand_vec();
        end
        send(m, v);
    endtask

    initial
    begin : stimulus
        logic [njcs_pkg::DOF_W-1:0] dof_plan [6];
        int                         p;
        int                         k;
        joint_vec_t                 v;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, all joints in use from reset, no idling
        send(njcs_pkg::MODE_QUERY, rand_vec());              // empty table
        send(njcs_pkg::MODE_INSERT, '0);                     // node 0
        send(njcs_pkg::MODE_QUERY, {8{16'h8000}});           // half turn on every joint
        send(njcs_pkg::MODE_INSERT, {8{16'hFFFF}});          // node 1, one step below zero
        send(njcs_pkg::MODE_QUERY, '0);
        send(njcs_pkg::MODE_INSERT, '0);                     // node 2, duplicate of node 0
        send(njcs_pkg::MODE_QUERY, {8{16'h0001}});           // two-way tie between nodes 0 and 2, lowest wins
        send(njcs_pkg::MODE_QUERY, {8{16'h7FFF}});
        send(njcs_pkg::MODE_QUERY, {4{16'h8000, 16'h0000}});
        v = {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h0000, 16'h8001, 16'h4000, 16'hC000};
        send(njcs_pkg::MODE_INSERT, v);
        v[3] ^= 16'h8000;
        send(njcs_pkg::MODE_QUERY, v);
        send(njcs_pkg::MODE_INSERT, rand_vec());

        // joint count corners: one joint, zero acting as one, above the lane count
        write_dof(4'd1);
        v = rand_vec();
        v[0] = '0;
        send(njcs_pkg::MODE_QUERY, v);
        write_dof(4'd0);
        v = rand_vec();
        v[0] = 16'h8000;
        send(njcs_pkg::MODE_QUERY, v);
        write_dof(4'd15);
        send(njcs_pkg::MODE_QUERY, {8{16'h0001}});
        write_dof(4'd9);
        send(njcs_pkg::MODE_INSERT, rand_vec());
        send(njcs_pkg::MODE_QUERY, rand_vec());

        // random phases: idling one way, then the other, then none
        dof_plan = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd3,
                     njcs_pkg::DOF_W'($urandom_range(2, 7))};
        for (p = 0; p < 6; p++)
        begin
            write_dof(dof_plan[p]);
            send_idle = (p < 2) ? 35 : ((p < 4) ? 53 : 0);
            recv_idle = (p < 2) ? 53 : ((p < 4) ? 35 : 0);
            if (p == 4)
                hold_req = 1'b1;
            for (k = 0; k < 90; k++)
            begin
                if (k == 45)
                    drain();
                random_item();
            end
        end

        // scans over every stored slot, all joints and then one
        write_dof(4'd8);
        send(njcs_pkg::MODE_QUERY, placed[placed.size() - 1]);
        for (k = 0; k < 6; k++)
            send(njcs_pkg::MODE_QUERY,
                 nudge(placed[$urandom_range(placed.size() - 1)], 500));
        send(njcs_pkg::MODE_INSERT, rand_vec());
        write_dof(4'd1);
        send(njcs_pkg::MODE_QUERY, rand_vec());
        send(njcs_pkg::MODE_QUERY, {8{16'h8000}});

        // let the last results arrive, then allow one full scan of settling
        drain();
        repeat (1100) @(posedge clk);

        $display("covered %0d result beats: %0d nearest scans, %0d on an empty table, %0d refused",
                 results, queries, empties, fulls);
        $display("joint counts 0, 1, 3, 8, 9, 15 and %0d used; table holds %0d nodes",
                 dof_plan[5], placed.size());
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial
    begin : watchdog
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/njcs_pkg.sv
rtl/njcs_lane.sv
rtl/njcs_merge.sv
rtl/nearest_joint_config_search.sv
tb/sv/nearest_result_checker.sv
tb/sv/tb_nearest_joint_config_search.sv
